FILE: rtl/core/sgs_pkg.sv
package sgs_pkg;

  // Sizes of the filter.
  localparam int MAX_HALF   = 6;
  localparam int SAMPLE_W   = 16;
  localparam int HIST_DEPTH = 2 * MAX_HALF + 1;
  localparam int COEFF_W    = 18;
  localparam int FRAC_W     = 16;
  localparam int SMOOTH_W   = 18;
  localparam int HALF_CFG_W = 3;
  localparam int HALF_RESET = 2;

  // Derived widths.
  localparam int HALF_W    = $clog2(MAX_HALF + 1);
  localparam int DIST_W    = $clog2(HIST_DEPTH);
  localparam int SEEN_W    = $clog2(HIST_DEPTH + 1);
  localparam int IDX_W     = $clog2(2 * HIST_DEPTH + 2 * MAX_HALF) + 1;
  localparam int CFG_IDX_W = $clog2(MAX_HALF + 2);
  localparam int CFG_DATA_W = COEFF_W;
  localparam int PROD_W    = COEFF_W + SAMPLE_W + 2;
  localparam int NTERM     = MAX_HALF + 2;
  localparam int ACC_W     = PROD_W + $clog2(NTERM);
  localparam int N3        = (NTERM + 1) / 2;
  localparam int N4        = (N3 + 1) / 2;

  // Job queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic signed [SMOOTH_W-1:0] SMOOTH_MAX = {1'b0, {(SMOOTH_W-1){1'b1}}};
  localparam logic signed [SMOOTH_W-1:0] SMOOTH_MIN = {1'b1, {(SMOOTH_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ROUND_ADD =
    {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
  localparam logic signed [COEFF_W-1:0] COEFF_ONE =
    {{(COEFF_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WIDTH   = 0,
    CFG_COEFF_CENTER = 1
  } sgs_cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                end_of_record;
  } sgs_in_t;

  typedef struct packed {
    logic signed [SMOOTH_W-1:0] smoothed;
    logic                       last_of_record;
  } sgs_out_t;

  typedef logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] sgs_hist_t;
  typedef logic signed [COEFF_W-1:0] sgs_coeff_t;
  typedef sgs_coeff_t [MAX_HALF:0] sgs_coeffs_t;

  // One accepted sample that causes results: a snapshot of the history, the
  // newest sample's position, the first result position, h and the eor flag.
  typedef struct packed {
    sgs_hist_t         hist;
    logic [DIST_W-1:0] last;
    logic [DIST_W-1:0] first;
    logic [HALF_W-1:0] half;
    logic              eor;
  } sgs_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sgs_qstat_t;

  // Distance back from the newest sample of the tap at position n -/+ k,
  // with the record mirrored at both ends and clamped into short records.
  function automatic logic [DIST_W-1:0] tap_dist(input logic [DIST_W-1:0] n,
                                                 input logic [HALF_W-1:0] k,
                                                 input logic              minus,
                                                 input logic [DIST_W-1:0] last);
    logic signed [IDX_W-1:0] nn;
    logic signed [IDX_W-1:0] kk;
    logic signed [IDX_W-1:0] lst;
    logic signed [IDX_W-1:0] one;
    logic signed [IDX_W-1:0] idx;
    logic signed [IDX_W-1:0] m;
    logic signed [IDX_W-1:0] d;
    nn  = $signed({{(IDX_W-DIST_W){1'b0}}, n});
    kk  = $signed({{(IDX_W-HALF_W){1'b0}}, k});
    lst = $signed({{(IDX_W-DIST_W){1'b0}}, last});
    one = $signed({{(IDX_W-1){1'b0}}, 1'b1});
    idx = minus ? (nn - kk) : (nn + kk);
    if (idx < 0) begin
      m = -idx - one;
      if (m > lst) begin
        m = lst;
      end
    end else if (idx > lst) begin
      m = lst + lst + one - idx;
      if (m < 0) begin
        m = '0;
      end
    end else begin
      m = idx;
    end
    d = lst - m;
    return d[DIST_W-1:0];
  endfunction

endpackage

FILE: rtl/core/savitzky_golay_smoother_unit.sv
// Savitzky-Golay smoother with a symmetric window of 2h+1 taps.
// Input channel: in_valid_i / in_stall_o carry one sample request, with
// end_of_record marking the final sample of a record. Output channel:
// out_valid_o / out_stall_i carry one smoothed result, with last_of_record
// set on the final result of the record. A request moves on a rising edge
// with valid high and stall low.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 is the half
// width, 1 the center weight, 2 to 7 the weights at offset one to six) and
// cfg_data_i. Write only while the filter is idle; cfg_ready_o is always high.
// The result for sample n passes the job queue and the tap, product, sum and
// output registers once sample n+h is accepted. Throughput is one sample per
// cycle while no result is held; a record's last sample releases up to h+1
// results, one per cycle; in_stall_o is high if the two-entry queue is full.
// Reset clears the history, the sample count, the queue and the pipeline,
// and loads h = 2 with a center weight of 1.0 and all other weights zero.
// While out_stall_i holds a result, the whole arithmetic pipeline freezes;
// the front keeps accepting samples until the job queue is full.
module savitzky_golay_smoother_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sgs_pkg::sgs_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sgs_pkg::sgs_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sgs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import sgs_pkg::*;

  // Configuration registers.
  logic [HALF_CFG_W-1:0] half_width_q, half_width_d;
  sgs_coeffs_t           coeff_q, coeff_d;
  logic                  cfg_write;

  // Front to back signals.
  logic       push;
  logic       pop;
  sgs_job_t   push_job;
  sgs_job_t   head_job;
  sgs_qstat_t qstat;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Register decode. Indices that address no register are dropped.
  always_comb begin
    half_width_d = half_width_q;
    coeff_d      = coeff_q;
    if (cfg_write) begin
      if (cfg_index_i == CFG_HALF_WIDTH) begin
        half_width_d = cfg_data_i[HALF_CFG_W-1:0];
      end
      for (int k = 0; k <= MAX_HALF; k++) begin
        if (cfg_index_i == CFG_IDX_W'(int'(CFG_COEFF_CENTER) + k)) begin
          coeff_d[k] = $signed(cfg_data_i[COEFF_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HALF_CFG_W'(HALF_RESET);
      coeff_q      <= {{(MAX_HALF*COEFF_W){1'b0}}, COEFF_ONE};
    end else begin
      half_width_q <= half_width_d;
      coeff_q      <= coeff_d;
    end
  end

  // The front shifts the sample history and decides which results a sample
  // causes; each such sample becomes one job with its own history snapshot.
  sgs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .half_width_i (half_width_q),
    .qstat_i      (qstat),
    .push_o       (push),
    .job_o        (push_job)
  );

  // Short queue that lets the front keep taking samples during a flush.
  sgs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .stat_o (qstat)
  );

  // With a job queued and no result held, the back issues a result position per
  // cycle into the tap select, multiply, adder tree and round/saturate pipeline.
  sgs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .job_i       (head_job),
    .pop_o       (pop),
    .coeffs_i    (coeff_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/core/sgs_fifo.sv
module sgs_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sgs_pkg::sgs_job_t   job_i,
  input  logic                pop_i,
  output sgs_pkg::sgs_job_t   head_o,
  output sgs_pkg::sgs_qstat_t stat_o
);
  import sgs_pkg::*;

  sgs_job_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // The front must hold off while the queue is full.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i)
    else $error("job queue written while full");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("job queue count out of range");

endmodule

FILE: rtl/core/sgs_front.sv
module sgs_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  sgs_pkg::sgs_in_t                   in_data_i,
  output logic                               in_stall_o,
  input  logic [sgs_pkg::HALF_CFG_W-1:0]     half_width_i,
  input  sgs_pkg::sgs_qstat_t                qstat_i,
  output logic                               push_o,
  output sgs_pkg::sgs_job_t                  job_o
);
  import sgs_pkg::*;

  sgs_hist_t         hist_q, hist_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [SEEN_W-1:0] seen_new;
  logic [DIST_W-1:0] last;
  logic [HALF_W-1:0] half;
  logic              accept;

  always_comb begin
    // Out-of-range half widths are clamped into 1..MAX_HALF.
    if (half_width_i == '0) begin
      half = HALF_W'(1);
    end else if (half_width_i > HALF_CFG_W'(MAX_HALF)) begin
      half = HALF_W'(MAX_HALF);
    end else begin
      half = HALF_W'(half_width_i);
    end

    accept   = in_valid_i && !qstat_i.full;
    seen_new = (seen_q < SEEN_W'(HIST_DEPTH)) ? seen_q + 1'b1 : seen_q;
    last     = DIST_W'(seen_new - 1'b1);

    hist_d = {hist_q[HIST_DEPTH-2:0], in_data_i.sample};
    seen_d = in_data_i.end_of_record ? '0 : seen_new;

    job_o.hist  = hist_d;
    job_o.last  = last;
    job_o.first = (last >= DIST_W'(half)) ? last - DIST_W'(half) : '0;
    job_o.half  = half;
    job_o.eor   = in_data_i.end_of_record;

    push_o = accept && (in_data_i.end_of_record || (last >= DIST_W'(half)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      seen_q <= '0;
    end else if (accept) begin
      hist_q <= hist_d;
      seen_q <= seen_d;
    end
  end

  assign in_stall_o = qstat_i.full;

  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SEEN_W'(HIST_DEPTH))
    else $error("sample count beyond history depth");

endmodule

FILE: rtl/core/sgs_back.sv
module sgs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sgs_pkg::sgs_qstat_t   qstat_i,
  input  sgs_pkg::sgs_job_t     job_i,
  output logic                  pop_o,
  input  sgs_pkg::sgs_coeffs_t  coeffs_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sgs_pkg::sgs_out_t     out_data_o
);
  import sgs_pkg::*;

  logic                     en;
  logic                     issue;
  logic                     final_item;
  logic [DIST_W-1:0]        n;
  logic [HALF_W-1:0]        cnt_q;
  logic [DIST_W-1:0]        d_m [MAX_HALF+1];
  logic [DIST_W-1:0]        d_p [MAX_HALF+1];

  // Stage 1: selected tap samples.
  logic [SAMPLE_W-1:0]      xm_d [MAX_HALF+1];
  logic [SAMPLE_W-1:0]      xp_d [MAX_HALF+1];
  logic [SAMPLE_W-1:0]      s1_xm_q [MAX_HALF+1];
  logic [SAMPLE_W-1:0]      s1_xp_q [MAX_HALF+1];
  logic                     s1_valid_q, s1_last_q;

  // Stage 2: products.
  logic [SAMPLE_W:0]        pair;
  logic signed [PROD_W-1:0] prod_d [MAX_HALF+1];
  logic signed [PROD_W-1:0] s2_prod_q [MAX_HALF+1];
  logic                     s2_valid_q, s2_last_q;

  // Stages 3 and 4: adder tree.
  logic signed [ACC_W-1:0]  term [2*N3];
  logic signed [ACC_W-1:0]  s3_d [N3];
  logic signed [ACC_W-1:0]  s3_q [N3];
  logic signed [ACC_W-1:0]  t4 [2*N4];
  logic signed [ACC_W-1:0]  s4_d [N4];
  logic signed [ACC_W-1:0]  s4_q [N4];
  logic                     s3_valid_q, s3_last_q;
  logic                     s4_valid_q, s4_last_q;

  // Output stage.
  logic signed [ACC_W-1:0]    total;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [ACC_W-1:0]    sat_hi;
  logic signed [ACC_W-1:0]    sat_lo;
  logic signed [SMOOTH_W-1:0] res;
  sgs_out_t                   out_q;
  logic                       out_valid_q;

  assign sat_hi = ACC_W'(SMOOTH_MAX);
  assign sat_lo = ACC_W'(SMOOTH_MIN);

  // The whole pipeline advances unless a finished result is held.
  assign en = !(out_valid_q && out_stall_i);

  always_comb begin
    n          = DIST_W'(job_i.first + DIST_W'(cnt_q));
    final_item = !job_i.eor || (n == job_i.last);
    issue      = en && !qstat_i.empty;
    pop_o      = issue && final_item;
    for (int k = 0; k <= MAX_HALF; k++) begin
      d_m[k] = tap_dist(n, HALF_W'(k), 1'b1, job_i.last);
      d_p[k] = tap_dist(n, HALF_W'(k), 1'b0, job_i.last);
      if (HALF_W'(k) <= job_i.half) begin
        xm_d[k] = job_i.hist[d_m[k]];
        xp_d[k] = (k == 0) ? '0 : job_i.hist[d_p[k]];
      end else begin
        xm_d[k] = '0;
        xp_d[k] = '0;
      end
    end
  end

  always_comb begin
    pair = '0;
    for (int k = 0; k <= MAX_HALF; k++) begin
      pair      = {1'b0, s1_xm_q[k]} + {1'b0, s1_xp_q[k]};
      prod_d[k] = $signed(coeffs_i[k]) * $signed({1'b0, pair});
    end
  end

  always_comb begin
    for (int j = 0; j < 2 * N3; j++) begin
      if (j <= MAX_HALF) begin
        term[j] = ACC_W'(s2_prod_q[j]);
      end else if (j == MAX_HALF + 1) begin
        term[j] = ROUND_ADD;
      end else begin
        term[j] = '0;
      end
    end
    for (int i = 0; i < N3; i++) begin
      s3_d[i] = term[2*i] + term[2*i+1];
    end
    for (int j = 0; j < 2 * N4; j++) begin
      if (j < N3) begin
        t4[j] = s3_q[j];
      end else begin
        t4[j] = '0;
      end
    end
    for (int i = 0; i < N4; i++) begin
      s4_d[i] = t4[2*i] + t4[2*i+1];
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < N4; i++) begin
      total = total + s4_q[i];
    end
    shifted = total >>> FRAC_W;
    if (shifted > sat_hi) begin
      res = SMOOTH_MAX;
    end else if (shifted < sat_lo) begin
      res = SMOOTH_MIN;
    end else begin
      res = shifted[SMOOTH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      if (issue) begin
        cnt_q <= final_item ? '0 : cnt_q + 1'b1;
      end
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_xm_q   <= xm_d;
      s1_xp_q   <= xp_d;
      s1_last_q <= job_i.eor && (n == job_i.last);
      s2_prod_q <= prod_d;
      s2_last_q <= s1_last_q;
      s3_q      <= s3_d;
      s3_last_q <= s2_last_q;
      s4_q      <= s4_d;
      s4_last_q <= s3_last_q;
      out_q.smoothed       <= res;
      out_q.last_of_record <= s4_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A record never flushes more than h+1 results from one sample.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= HALF_W'(MAX_HALF))
    else $error("flush counter beyond half width");

  // A held result freezes the whole pipeline.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(s4_valid_q) && $stable(cnt_q)))
    else $error("pipeline moved while output held");

endmodule

FILE: sim/sgs_smooth_checker.sv
`timescale 1ns / 100ps

// Watches the sample, result and register channels of the smoother. It keeps
// its own copy of the filter state, works out the smoothed values due for each
// accepted sample, and compares every accepted result with the oldest one due.
module sgs_smooth_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  sgs_pkg::sgs_in_t               in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  sgs_pkg::sgs_out_t              out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sgs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             pending_o,
  output int                             fails_o
);
  import sgs_pkg::*;

  logic [SAMPLE_W-1:0]   history [0:HIST_DEPTH-1];
  int                    seen;
  logic [HALF_CFG_W-1:0] half_reg;
  sgs_coeff_t            weights [0:MAX_HALF];
  sgs_out_t              smoothed_due [$];

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    fails_o = fails_o + 1;
  endtask

  function automatic int eff_half();
    int h;
    h = int'(half_reg);
    if (h < 1) h = 1;
    if (h > MAX_HALF) h = MAX_HALF;
    return h;
  endfunction

  // Sample at record position pos, mirrored at both ends with the edge sample
  // repeated and clamped into short records; newest is the newest position.
  function automatic longint tap_value(input int pos, input int newest);
    int m;
    int d;
    m = pos;
    if (pos < 0) begin
      m = -1 - pos;
      if (m > newest) m = newest;
    end else if (pos > newest) begin
      m = 2 * newest + 1 - pos;
      if (m < 0) m = 0;
    end
    d = newest - m;
    if (d < 0 || d >= HIST_DEPTH) return 64'sd0;
    return longint'(history[d]);
  endfunction

  function automatic logic signed [SMOOTH_W-1:0] filter_at(input int n, input int newest,
                                                          input int h);
    longint acc;
    longint q;
    acc = longint'(weights[0]) * tap_value(n, newest);
    for (int k = 1; k <= h; k++) begin
      acc += longint'(weights[k]) * (tap_value(n - k, newest) + tap_value(n + k, newest));
    end
    // Round half up, then clip to the output range.
    q = (acc + 64'sd32768) >>> FRAC_W;
    if (q < longint'(SMOOTH_MIN)) q = longint'(SMOOTH_MIN);
    if (q > longint'(SMOOTH_MAX)) q = longint'(SMOOTH_MAX);
    return q[SMOOTH_W-1:0];
  endfunction

  function automatic void predict_smoothed(input sgs_in_t item);
    int newest;
    int h;
    int first;
    h = eff_half();
    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
      history[i] = history[i-1];
    end
    history[0] = item.sample;
    if (seen < HIST_DEPTH) seen++;
    newest = seen - 1;
    if (!item.end_of_record) begin
      if (newest >= h) begin
        smoothed_due.push_back('{smoothed: filter_at(newest - h, newest, h),
                                 last_of_record: 1'b0});
      end
    end else begin
      // The closing sample flushes the tail of the record.
      first = (newest - h < 0) ? 0 : newest - h;
      for (int n = first; n <= newest; n++) begin
        smoothed_due.push_back('{smoothed: filter_at(n, newest, h),
                                 last_of_record: (n == newest)});
      end
      seen = 0;
    end
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_HALF_WIDTH) begin
      half_reg = data[HALF_CFG_W-1:0];
    end else if (idx >= CFG_COEFF_CENTER && idx <= CFG_COEFF_CENTER + MAX_HALF) begin
      weights[idx - CFG_COEFF_CENTER] = data;
    end
  endfunction

  task automatic check_result(input sgs_out_t got);
    sgs_out_t want;
    if (smoothed_due.size() == 0) begin
      flag_mismatch("unexpected result", longint'($signed(got.smoothed)), longint'(0));
    end else begin
      want = smoothed_due.pop_front();
      if (got.smoothed !== want.smoothed) begin
        flag_mismatch("smoothed", longint'($signed(got.smoothed)),
                      longint'($signed(want.smoothed)));
      end
      if (got.last_of_record !== want.last_of_record) begin
        flag_mismatch("last_of_record", longint'(got.last_of_record),
                      longint'(want.last_of_record));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) history[i] = '0;
      for (int k = 0; k <= MAX_HALF; k++) weights[k] = '0;
      weights[0] = COEFF_ONE;
      half_reg = HALF_CFG_W'(HALF_RESET);
      seen = 0;
      smoothed_due.delete();
      fails_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (cfg_valid_i && cfg_ready_i) apply_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) predict_smoothed(in_data_i);
      pending_o <= smoothed_due.size();
    end
  end

endmodule

FILE: sim/tb_savitzky_golay_smoother_unit.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the Savitzky-Golay smoother. The checker instance
// beside the block does all prediction and comparison; this module only feeds
// sample requests, register writes and receiver stalls, and reads the counts
// of pending results and failures.
module tb_savitzky_golay_smoother_unit;
  import sgs_pkg::*;

  localparam int RANDOM_ITEMS  = 180;
  // Time for the pipeline and a full flush of seven results, with margin.
  localparam int SETTLE_CYCLES = 24;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  sgs_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  sgs_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // When set, neither side idles, so the block runs at full rate.
  logic quiet_run  = 1'b0;
  int   stall_hold = 0;
  int   pending_results;
  int   mismatches;
  int   items_sent = 0;

  savitzky_golay_smoother_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  sgs_smooth_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending_results),
    .fails_o     (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop, several times the slowest correct run.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // The receiver stalls in runs of random length: mostly short, now and then
  // long, and never while a quiet phase is running.
  always @(posedge clk_i) begin : receiver_stall
    int r;
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (quiet_run || r < 50) begin
        out_stall_i <= 1'b0;
        stall_hold  <= $urandom_range(0, 5);
      end else if (r < 85) begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(0, 2);
      end else if (r < 97) begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(3, 9);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(19, 39);
      end
    end
  end

  // Idle cycles the sender leaves before a request.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Sample values mix full-range noise, small counts, the edges of the range
  // and a band around mid scale.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return SAMPLE_W'($urandom);
    if (r < 7) return SAMPLE_W'($urandom_range(0, 255));
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return SAMPLE_W'(1);
        2:       return '1;
        default: return {{(SAMPLE_W-1){1'b1}}, 1'b0};
      endcase
    end
    return SAMPLE_W'($urandom_range(32768 - 300, 32768 + 300));
  endfunction

  // Weight styles: 0 moderate weights that rarely clip, 1 any 18-bit pattern,
  // 2 a pick of the extreme and landmark values.
  function automatic sgs_coeff_t pick_weight(input int style, input bit center);
    sgs_coeff_t w;
    case (style)
      0: begin
        if (center) w = COEFF_W'($urandom_range(20000, 70000));
        else        w = COEFF_W'(int'($urandom_range(0, 40000)) - 20000);
      end
      1: w = COEFF_W'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       w = 18'sh1FFFF;
          1:       w = 18'sh20000;
          2:       w = COEFF_ONE;
          3:       w = -18'sd1;
          default: w = '0;
        endcase
      end
    endcase
    return w;
  endfunction

  // One sample request; valid stays high between back-to-back requests.
  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic eor);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{sample: s, end_of_record: eor};
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_record(input int len);
    for (int i = 0; i < len; i++) begin
      push_sample(pick_sample(), i == len - 1);
    end
  endtask

  // Holds the sender back until every result due has left the block, then
  // lets the pipeline settle so a register write finds it idle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high so that a run of writes needs no second
  // assignment within one step; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_filter(input logic [CFG_DATA_W-1:0] half_word, input sgs_coeffs_t wts);
    write_reg(CFG_HALF_WIDTH, half_word);
    for (int k = 0; k <= MAX_HALF; k++) begin
      write_reg(CFG_IDX_W'(int'(CFG_COEFF_CENTER) + k), wts[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    sgs_coeffs_t             wts;
    logic [CFG_DATA_W-1:0]   half_word;
    int                      style;
    int                      r;
    int                      len;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: h of two and a center weight of one pass the record
    // through unchanged, edges included.
    push_sample(16'd0, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'd1, 1'b0);
    push_sample(16'd40000, 1'b1);
    wait_drained();

    // Half width above the maximum, extreme weights that clip both ways, and
    // a record shorter than the window so the mirror indices clamp. The upper
    // bits of the half-width word are all ones here and must be ignored.
    wts[0] = 18'sh1FFFF;
    wts[1] = 18'sh20000;
    wts[2] = 18'sh1FFFF;
    wts[3] = 18'sd32768;
    wts[4] = -18'sd32768;
    wts[5] = 18'sd1;
    wts[6] = -18'sd1;
    load_filter(18'h3FFFF, wts);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'd0, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'd0, 1'b0);
    push_sample(16'd12345, 1'b0);
    push_sample(16'd54321, 1'b1);
    wait_drained();

    // Half width zero acts as one. Weights of a half put the sums exactly
    // halfway between integers, so ties must round up on both signs.
    wts    = '0;
    wts[0] = -18'sd32768;
    wts[1] = 18'sd32768;
    load_filter('0, wts);
    push_sample(16'd12345, 1'b1);
    push_sample(16'd1, 1'b0);
    push_sample(16'd0, 1'b0);
    push_sample(16'd3, 1'b1);
    wait_drained();

    // The half width changes in the middle of a record; the new width takes
    // over from the next sample on.
    wts    = '0;
    wts[0] = 18'sd43691;
    wts[1] = 18'sd10923;
    load_filter(18'd1, wts);
    push_sample(16'd100, 1'b0);
    push_sample(16'd200, 1'b0);
    push_sample(16'd300, 1'b0);
    push_sample(16'd400, 1'b0);
    wait_drained();
    write_reg(CFG_HALF_WIDTH, 18'd3);
    cfg_valid_i <= 1'b0;
    push_sample(16'd500, 1'b0);
    push_sample(16'd600, 1'b0);
    push_sample(16'd700, 1'b1);

    // Random phases: each waits for the block to drain, loads new settings
    // and sends a few records. Long records run the sample count into
    // saturation, short ones exercise the clamped mirror.
    while (items_sent < RANDOM_ITEMS) begin
      wait_drained();
      quiet_run <= ($urandom_range(0, 3) == 0);
      half_word = CFG_DATA_W'($urandom);
      half_word[HALF_CFG_W-1:0] = HALF_CFG_W'($urandom_range(0, 7));
      r = $urandom_range(0, 9);
      style = (r < 5) ? 0 : (r < 8) ? 1 : 2;
      for (int k = 0; k <= MAX_HALF; k++) begin
        wts[k] = pick_weight(style, k == 0);
      end
      load_filter(half_word, wts);
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 9);
        if (r < 2)      len = $urandom_range(1, 3);
        else if (r < 7) len = $urandom_range(4, 14);
        else            len = $urandom_range(15, 30);
        send_record(len);
      end
    end

    wait_drained();
    if (mismatches == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sgs_pkg.sv
rtl/core/sgs_fifo.sv
rtl/core/sgs_front.sv
rtl/core/sgs_back.sv
rtl/core/savitzky_golay_smoother_unit.sv
sim/sgs_smooth_checker.sv
sim/tb_savitzky_golay_smoother_unit.sv
